>>> design/b2a_pkg.sv
// Package for the binary to ASCII decimal converter.
// Holds shared widths, constants and the cell control struct; no dependencies.
package b2a_pkg;

  localparam int VALUE_BITS_DEF = 32;   // default conversion width
  localparam int VALUE_W        = 32;   // input field width
  localparam int DIGIT_W        = 4;    // one BCD digit
  localparam int CHAR_W         = 6;    // ASCII digit code as carried
  localparam int OUT_DATA_W     = 8;    // char padded to a byte

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Control shared by every cell of the digit chain.
  typedef struct packed {
    logic clear;   // zero the digit (new beat taken)
    logic shift;   // one double-dabble step
  } cell_ctrl_t;

endpackage

>>> design/binary_to_ascii_decimal.sv
// Binary to ASCII decimal converter, top level.
// Depends on b2a_pkg and b2a_cell.
//
// Each input beat carries one unsigned number in in_tdata; only the low
// VALUE_BITS bits (at most the 32 of the field) are converted. The block
// answers with one output beat per decimal digit, most significant first,
// leading zeros dropped; zero gives the single character '0'. Each output
// beat holds the ASCII code in out_tdata[5:0] and out_tlast marks the final
// (least significant) digit. Conversion is a double-dabble shift through a
// row of BCD digit cells: every converted input bit (32 by default) is
// shifted in, msb first, then the leading digit is located, then the
// digits are emitted in turn, holding while the sink stalls. One number
// is converted at a time; in_tready is high while the block waits for
// work, including while the final digit of the previous number still
// sits in the output register.
module binary_to_ascii_decimal import b2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,   // [31:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                  out_tlast   // last_digit
);

  // Bits actually converted and the digits they can need.
  localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int NDIG     = ((EFF_BITS * 30103) / 100000) + 1;
  localparam int IDX_W    = $clog2(NDIG);
  localparam int CNT_W    = $clog2(EFF_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FIND,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [EFF_BITS-1:0] sreg_r;     // binary value, shifted out msb first
  logic [CNT_W-1:0]    cnt_r;      // shift steps done
  logic [IDX_W-1:0]    idx_r;      // digit to emit next
  logic                out_tvalid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_tlast_r;

  logic                in_accept;
  logic                emit_load;
  cell_ctrl_t          cell_ctrl;
  logic [NDIG:0]       carry;
  logic [DIGIT_W-1:0]  digit [NDIG];
  logic [IDX_W-1:0]    msd_idx;
  logic                bcd_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  // output register free or draining this cycle
  assign emit_load  = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  assign cell_ctrl.clear = in_accept;
  assign cell_ctrl.shift = (state_r == ST_SHIFT);

  // msb of the binary word enters the lowest digit
  assign carry[0] = sreg_r[EFF_BITS-1];

  for (genvar g = 0; g < NDIG; g++) begin : g_cell
    b2a_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .bit_i   (carry[g]),
      .bit_o   (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  // Highest nonzero digit; zero value falls back to the units digit.
  always_comb begin
    msd_idx = '0;
    bcd_ok  = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (digit[i] != '0) msd_idx = IDX_W'(i);
      if (digit[i] > DIGIT_W'(9)) bcd_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // drained with nothing new behind it
      if (out_tvalid_r && out_tready && !emit_load) out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            sreg_r  <= in_tdata[EFF_BITS-1:0];
            cnt_r   <= '0;
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          sreg_r <= {sreg_r[EFF_BITS-2:0], 1'b0};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(EFF_BITS - 1)) state_r <= ST_FIND;
        end
        ST_FIND: begin
          idx_r   <= msd_idx;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_tvalid_r <= 1'b1;
            out_char_r   <= ASCII_ZERO + CHAR_W'(digit[idx_r]);
            out_tlast_r  <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r - IDX_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_tlast_r;

  // the top cell never overflows: the chain is sized for the full range
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.shift |-> !carry[NDIG])
    else $error("digit chain overflow");

  // every cell holds a valid decimal digit once the shift is done
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> bcd_ok)
    else $error("cell holds a non-decimal digit");

  // loading the units digit ends the number and flags it last
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (idx_r == '0)) |=> (state_r == ST_IDLE) && out_tvalid && out_tlast)
    else $error("last digit not closing the number");

  // no number is taken while digits are still being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !in_tready)
    else $error("input taken during emission");

endmodule

>>> design/b2a_cell.sv
// One BCD digit cell of the double-dabble chain.
// Depends on b2a_pkg (DIGIT_W, cell_ctrl_t).
module b2a_cell import b2a_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_i,    // from the next lower digit
  output logic               bit_o,    // to the next higher digit
  output logic [DIGIT_W-1:0] digit_o
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction so the shift doubles in decimal
  assign adj     = (digit_r >= DIGIT_W'(5)) ? digit_r + DIGIT_W'(3) : digit_r;
  assign bit_o   = adj[DIGIT_W-1];
  assign digit_o = digit_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= '0;
    end else if (ctrl.shift) begin
      digit_r <= {adj[DIGIT_W-2:0], bit_i};
    end
  end

endmodule
